// ----- hdl/stone2_pkg.sv -----
// Shared constants and helper functions for the Stone II oil relperm pipeline.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package stone2_pkg;

  localparam int FRAC_BITS = 16;
  localparam int KR_W      = 17;
  localparam int DER_W     = 32;
  localparam int CFG_W     = 17;
  localparam int OIL_W     = 31;
  localparam int DIV_W     = DER_W + FRAC_BITS;
  localparam int SAT_W     = 96;

  function automatic logic signed [DER_W-1:0] sat_s32(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi_lim;
    logic signed [SAT_W-1:0] lo_lim;
    hi_lim = $signed({{(SAT_W-DER_W+1){1'b0}}, {(DER_W-1){1'b1}}});
    lo_lim = $signed({{(SAT_W-DER_W+1){1'b1}}, {(DER_W-1){1'b0}}});
    if (x > hi_lim) begin
      sat_s32 = hi_lim[DER_W-1:0];
    end else if (x < lo_lim) begin
      sat_s32 = lo_lim[DER_W-1:0];
    end else begin
      sat_s32 = x[DER_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/stone2_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Uses stone2_pkg; the divisor must stay constant while items are in flight.
`default_nettype none
module stone2_div import stone2_pkg::*; #(
  parameter int W  = DIV_W,
  parameter int CW = CFG_W
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [CW-1:0] divisor,
  output logic      [W-1:0]  quotient
);

  logic [W-1:0]  dq_r  [W];
  logic [CW-1:0] rem_r [W-1];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W-1:0]  dq_in;
    logic [CW-1:0] rem_in;
    logic [CW:0]   sh;
    logic          ge;
    if (s == 0) begin : g_first
      assign dq_in  = dividend;
      assign rem_in = '0;
    end else begin : g_next
      assign dq_in  = dq_r[s-1];
      assign rem_in = rem_r[s-1];
    end
    assign sh = {rem_in, dq_in[W-1]};
    assign ge = (sh >= {1'b0, divisor});
    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[s] <= {dq_in[W-2:0], ge};
      end
    end
    if (s < W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? CW'(sh - {1'b0, divisor}) : sh[CW-1:0];
        end
      end
    end
  end

  assign quotient = dq_r[W-1];

endmodule
`default_nettype wire

// ----- hdl/stone2_mul.sv -----
// Two-stage signed multiplier: the first operand is split in halves, partial
// products are registered, then summed into a registered full product. Uses stone2_pkg.
`default_nettype none
module stone2_mul import stone2_pkg::*; #(
  parameter int WA = DER_W,
  parameter int WB = DER_W
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [WA-1:0]    a,
  input  wire logic signed [WB-1:0]    b,
  output logic      signed [WA+WB-1:0] p
);

  localparam int LA = WA / 2;
  localparam int HA = WA - LA;

  logic signed [LA+WB:0]   p_lo_r;
  logic signed [HA+WB-1:0] p_hi_r;
  logic signed [WA+WB-1:0] p_r;
  logic signed [WA+WB-1:0] p_nxt;

  assign p_nxt = $signed({p_hi_r, {LA{1'b0}}}) + (WA+WB)'(p_lo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= $signed({1'b0, a[LA-1:0]}) * b;
      p_hi_r <= $signed(a[WA-1:LA]) * b;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ----- hdl/stone2_dly.sv -----
// Enabled delay line of fixed depth that carries side data along the pipeline.
// Uses stone2_pkg for its default width.
`default_nettype none
module stone2_dly import stone2_pkg::*; #(
  parameter int W = DER_W,
  parameter int D = 2
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[D-1];

endmodule
`default_nettype wire

// ----- hdl/stone_two_oil_relperm.sv -----
// Top level of the Stone II three-phase oil relative permeability pipeline.
// Uses stone2_pkg, stone2_div, stone2_mul and stone2_dly.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | four relperms, six derivatives
//   out_    | output    | out_valid/out_stall| oil relperm, three derivatives, clamp flag
//   cfg_    | input     | cfg_valid/cfg_ready| oil endpoint relperm
//
// One item enters every cycle unless in_stall holds it; derivatives are Q16.16.
// Registers in order: dividers, sums, split multiplier, shift, split multiplier, output.
// Reset clears the valid bits and sets the endpoint to 1.0.
// A stalled full output register freezes the whole pipeline; nothing is lost.
`default_nettype none
module stone_two_oil_relperm import stone2_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [KR_W-1:0]         in_water_relperm,
  input  wire logic [KR_W-1:0]         in_gas_relperm,
  input  wire logic [KR_W-1:0]         in_oil_water_relperm,
  input  wire logic [KR_W-1:0]         in_oil_gas_relperm,
  input  wire logic signed [DER_W-1:0] in_d_water_relperm_dsw,
  input  wire logic signed [DER_W-1:0] in_d_gas_relperm_dsg,
  input  wire logic signed [DER_W-1:0] in_d_oil_water_dso,
  input  wire logic signed [DER_W-1:0] in_d_oil_water_dsw,
  input  wire logic signed [DER_W-1:0] in_d_oil_gas_dso,
  input  wire logic signed [DER_W-1:0] in_d_oil_gas_dsg,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [OIL_W-1:0]             out_oil_relperm,
  output logic signed [DER_W-1:0]      out_d_oil_dso,
  output logic signed [DER_W-1:0]      out_d_oil_dsw,
  output logic signed [DER_W-1:0]      out_d_oil_dsg,
  output logic                         out_was_clamped,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_W-1:0]        cfg_oil_endpoint_relperm
);

  localparam int LAT    = DIV_W + 7;
  localparam int AWS    = KR_W + FRAC_BITS + 2;
  localparam int DWW    = DIV_W + 2;
  localparam int CS_W   = CFG_W + 1;
  localparam int AB_W   = 2 * AWS;
  localparam int K1_W   = AB_W - FRAC_BITS + 1;
  localparam int DWB_W  = DWW + AWS;
  localparam int TW_W   = DWB_W - FRAC_BITS + 1;
  localparam int SIDE_W = 2 * KR_W + 4 * DER_W + 2;
  localparam int M1S_W  = KR_W + 1 + 2 * DER_W;

  logic                adv;
  logic [LAT-1:0]      vld_r;
  logic [CFG_W-1:0]    endp_r;
  logic [CFG_W-1:0]    c_eff;
  logic signed [CS_W-1:0] c_s;

  assign adv       = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = vld_r[LAT-1] && out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];
  assign c_eff     = (endp_r == '0) ? CFG_W'(1) : endp_r;
  assign c_s       = $signed({1'b0, c_eff});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      endp_r <= CFG_W'(1 << FRAC_BITS);
    end else begin
      if (adv) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
      if (cfg_valid && cfg_ready) begin
        endp_r <= cfg_oil_endpoint_relperm;
      end
    end
  end

  // Dividers: x * ONE / c on magnitudes, sign restored afterwards.
  logic [DER_W-1:0] mag_w;
  logic [DER_W-1:0] mag_g;
  logic [DIV_W-1:0] qa;
  logic [DIV_W-1:0] qb;
  logic [DIV_W-1:0] qw;
  logic [DIV_W-1:0] qg;

  assign mag_w = in_d_oil_water_dsw[DER_W-1] ? (~in_d_oil_water_dsw + 1'b1)
                                             : in_d_oil_water_dsw;
  assign mag_g = in_d_oil_gas_dsg[DER_W-1] ? (~in_d_oil_gas_dsg + 1'b1)
                                           : in_d_oil_gas_dsg;

  stone2_div #(.W(DIV_W), .CW(CFG_W)) u_div_a (
    .clk(clk), .en(adv),
    .dividend({{(DIV_W-KR_W-FRAC_BITS){1'b0}}, in_oil_water_relperm, {FRAC_BITS{1'b0}}}),
    .divisor(c_eff), .quotient(qa));
  stone2_div #(.W(DIV_W), .CW(CFG_W)) u_div_b (
    .clk(clk), .en(adv),
    .dividend({{(DIV_W-KR_W-FRAC_BITS){1'b0}}, in_oil_gas_relperm, {FRAC_BITS{1'b0}}}),
    .divisor(c_eff), .quotient(qb));
  stone2_div #(.W(DIV_W), .CW(CFG_W)) u_div_w (
    .clk(clk), .en(adv), .dividend({mag_w, {FRAC_BITS{1'b0}}}),
    .divisor(c_eff), .quotient(qw));
  stone2_div #(.W(DIV_W), .CW(CFG_W)) u_div_g (
    .clk(clk), .en(adv), .dividend({mag_g, {FRAC_BITS{1'b0}}}),
    .divisor(c_eff), .quotient(qg));

  logic [SIDE_W-1:0] side_q;
  logic [KR_W-1:0]   krw_d;
  logic [KR_W-1:0]   krg_d;
  logic signed [DER_W-1:0] dkrw_d;
  logic signed [DER_W-1:0] dkrg_d;
  logic signed [DER_W-1:0] dowo_d;
  logic signed [DER_W-1:0] dogo_d;
  logic              negw_d;
  logic              negg_d;

  stone2_dly #(.W(SIDE_W), .D(DIV_W)) u_side (
    .clk(clk), .en(adv),
    .d({in_water_relperm, in_gas_relperm, in_d_water_relperm_dsw, in_d_gas_relperm_dsg,
        in_d_oil_water_dso, in_d_oil_gas_dso, in_d_oil_water_dsw[DER_W-1],
        in_d_oil_gas_dsg[DER_W-1]}),
    .q(side_q));

  assign {krw_d, krg_d, dkrw_d, dkrg_d, dowo_d, dogo_d, negw_d, negg_d} = side_q;

  // Sums A, B and the two derivative sums.
  logic signed [AWS-1:0]   a_r;
  logic signed [AWS-1:0]   b_r;
  logic signed [DWW-1:0]   dw_r;
  logic signed [DWW-1:0]   dg_r;
  logic signed [DWW-1:0]   qws;
  logic signed [DWW-1:0]   qgs;
  logic [M1S_W-1:0]        s1_side_r;
  logic signed [DER_W-1:0] s1_dowo_r;
  logic signed [DER_W-1:0] s1_dogo_r;

  assign qws = negw_d ? -$signed({2'b00, qw}) : $signed({2'b00, qw});
  assign qgs = negg_d ? -$signed({2'b00, qg}) : $signed({2'b00, qg});

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r       <= $signed(AWS'(qa[KR_W+FRAC_BITS-1:0]) + AWS'(krw_d));
      b_r       <= $signed(AWS'(qb[KR_W+FRAC_BITS-1:0]) + AWS'(krg_d));
      dw_r      <= qws + DWW'(dkrw_d);
      dg_r      <= qgs + DWW'(dkrg_d);
      s1_side_r <= {(KR_W+1)'(krw_d) + (KR_W+1)'(krg_d), dkrw_d, dkrg_d};
    end
  end

  logic signed [AB_W-1:0]        ab;
  logic signed [AWS+DER_W-1:0]   bo;
  logic signed [AWS+DER_W-1:0]   ag;
  logic signed [DWB_W-1:0]       dwb;
  logic signed [DWB_W-1:0]       adg;
  logic [M1S_W-1:0]              m1_side;

  stone2_mul #(.WA(AWS), .WB(AWS)) u_mul_ab (
    .clk(clk), .en(adv), .a(a_r), .b(b_r), .p(ab));
  stone2_mul #(.WA(AWS), .WB(DER_W)) u_mul_bo (
    .clk(clk), .en(adv), .a(b_r), .b(s1_dowo_r), .p(bo));
  stone2_mul #(.WA(AWS), .WB(DER_W)) u_mul_ag (
    .clk(clk), .en(adv), .a(a_r), .b(s1_dogo_r), .p(ag));
  stone2_mul #(.WA(DWW), .WB(AWS)) u_mul_dwb (
    .clk(clk), .en(adv), .a(dw_r), .b(b_r), .p(dwb));
  stone2_mul #(.WA(DWW), .WB(AWS)) u_mul_adg (
    .clk(clk), .en(adv), .a(dg_r), .b(a_r), .p(adg));

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dowo_r <= dowo_d;
      s1_dogo_r <= dogo_d;
    end
  end

  stone2_dly #(.W(M1S_W), .D(2)) u_m1_side (
    .clk(clk), .en(adv), .d(s1_side_r), .q(m1_side));

  logic [KR_W:0]           ksum_m;
  logic signed [DER_W-1:0] dkrw_m;
  logic signed [DER_W-1:0] dkrg_m;

  assign {ksum_m, dkrw_m, dkrg_m} = m1_side;

  // Shift the products back to Q16.16 and subtract the plain terms.
  logic signed [K1_W-1:0]  k1_r;
  logic signed [TW_W-1:0]  tw_r;
  logic signed [TW_W-1:0]  tg_r;
  logic signed [DER_W-1:0] dso_r;
  logic signed [AB_W-1:0]  ab_sh;
  logic signed [DWB_W-1:0] dwb_sh;
  logic signed [DWB_W-1:0] adg_sh;
  logic signed [SAT_W-1:0] so_sum;

  assign ab_sh  = ab >>> FRAC_BITS;
  assign dwb_sh = dwb >>> FRAC_BITS;
  assign adg_sh = adg >>> FRAC_BITS;
  assign so_sum = (SAT_W'(bo) + SAT_W'(ag)) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r  <= K1_W'(ab_sh - $signed(AB_W'(ksum_m)));
      tw_r  <= TW_W'(dwb_sh - DWB_W'(dkrw_m));
      tg_r  <= TW_W'(adg_sh - DWB_W'(dkrg_m));
      dso_r <= sat_s32(so_sum);
    end
  end

  logic signed [K1_W+CS_W-1:0] kc;
  logic signed [TW_W+CS_W-1:0] twc;
  logic signed [TW_W+CS_W-1:0] tgc;
  logic signed [DER_W-1:0]     dso_m;

  stone2_mul #(.WA(K1_W), .WB(CS_W)) u_mul_k (
    .clk(clk), .en(adv), .a(k1_r), .b(c_s), .p(kc));
  stone2_mul #(.WA(TW_W), .WB(CS_W)) u_mul_w (
    .clk(clk), .en(adv), .a(tw_r), .b(c_s), .p(twc));
  stone2_mul #(.WA(TW_W), .WB(CS_W)) u_mul_g (
    .clk(clk), .en(adv), .a(tg_r), .b(c_s), .p(tgc));
  stone2_dly #(.W(DER_W), .D(2)) u_m2_side (
    .clk(clk), .en(adv), .d(dso_r), .q(dso_m));

  // Clamp, saturate and hold the result.
  logic signed [SAT_W-1:0] k_sh;
  logic signed [SAT_W-1:0] w_sh;
  logic signed [SAT_W-1:0] g_sh;
  logic                    k_neg;
  logic [OIL_W-1:0]        oil_nxt;

  assign k_sh  = SAT_W'(kc) >>> FRAC_BITS;
  assign w_sh  = SAT_W'(twc) >>> FRAC_BITS;
  assign g_sh  = SAT_W'(tgc) >>> FRAC_BITS;
  assign k_neg = k_sh[SAT_W-1];
  assign oil_nxt = (k_sh > $signed({{(SAT_W-OIL_W){1'b0}}, {OIL_W{1'b1}}})) ? {OIL_W{1'b1}}
                                                                            : k_sh[OIL_W-1:0];

  logic [OIL_W-1:0]        oil_r;
  logic signed [DER_W-1:0] dso_out_r;
  logic signed [DER_W-1:0] dsw_out_r;
  logic signed [DER_W-1:0] dsg_out_r;
  logic                    clamp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      oil_r     <= k_neg ? '0 : oil_nxt;
      dso_out_r <= k_neg ? '0 : dso_m;
      dsw_out_r <= k_neg ? '0 : sat_s32(w_sh);
      dsg_out_r <= k_neg ? '0 : sat_s32(g_sh);
      clamp_r   <= k_neg;
    end
  end

  assign out_oil_relperm = oil_r;
  assign out_d_oil_dso   = dso_out_r;
  assign out_d_oil_dsw   = dsw_out_r;
  assign out_d_oil_dsg   = dsg_out_r;
  assign out_was_clamped = clamp_r;

endmodule
`default_nettype wire

// ----- hdl/stone2_chk.sv -----
// Port-level checker for stone_two_oil_relperm, bound to the top level.
// Uses stone2_pkg for the field widths.
`default_nettype none
module stone2_chk import stone2_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [OIL_W-1:0]        out_oil_relperm,
  input wire logic signed [DER_W-1:0] out_d_oil_dso,
  input wire logic signed [DER_W-1:0] out_d_oil_dsw,
  input wire logic signed [DER_W-1:0] out_d_oil_dsg,
  input wire logic                    out_was_clamped,
  input wire logic                    cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_oil_relperm)
      && $stable(out_d_oil_dso) && $stable(out_was_clamped))
    else $error("stalled result item changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input item withdrawn");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_clamped |-> out_oil_relperm == '0 && out_d_oil_dso == '0
      && out_d_oil_dsw == '0 && out_d_oil_dsg == '0)
    else $error("clamped item has nonzero fields");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind stone_two_oil_relperm stone2_chk u_chk (.*);
`default_nettype wire
